// ===== hdl/assert_macros.svh =====
// Assertion macros used by the print job queue datapath.
// Needs signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PJQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PJQ_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/pjq_pkg.sv =====
// Types and constants of the print job queue.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
package pjq_pkg;

	localparam int ID_W = 16;
	localparam int PAGE_W = 7;
	localparam int STATUS_W = 3;
	localparam int OP_W = 2;
	localparam int ENTRY_W = ID_W + PAGE_W;

	localparam logic [PAGE_W-1:0] MAX_PAGES = 7'd64;

	typedef enum logic [OP_W-1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_PRINT   = 2'd1,
		CMD_DELETE  = 2'd2
	} pjq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_NO_PAGES  = 3'd4
	} pjq_status_t;

	typedef struct packed {
		logic latch_in;
		logic enq;
		logic emit_full;
		logic emit_empty;
		logic prn_read;
		logic prn_load;
		logic emit_page;
		logic emit_nopage;
		logic del_start;
		logic del_step;
		logic del_finish;
	} pjq_cmd_t;

	typedef struct packed {
		pjq_op_t op;
		logic    full;
		logic    empty;
		logic    out_free;
		logic    walk_done;
		logic    page_zero;
		logic    page_last;
	} pjq_stat_t;

endpackage

// ===== hdl/pjq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the queue entries.
`timescale 1ns / 1ps
module pjq_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/pjq_ctrl.sv =====
// Controller state machine of the print job queue.
// Depends on pjq_pkg; drives the datapath command struct.
`timescale 1ns / 1ps
module pjq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pjq_pkg::pjq_stat_t stat,
	output pjq_pkg::pjq_cmd_t  cmd,
	output logic              busy
);
	import pjq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PLOAD,
		S_PAGES,
		S_DWALK,
		S_DDONE
	} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch_in = in_valid;
			end
			S_EXEC: begin
				unique case (stat.op)
					CMD_ENQUEUE: begin
						if (stat.out_free) begin
							cmd.emit_full = stat.full;
							cmd.enq = !stat.full;
						end
					end
					CMD_PRINT: begin
						if (stat.empty) begin
							cmd.emit_empty = stat.out_free;
						end else begin
							cmd.prn_read = 1'b1;
						end
					end
					CMD_DELETE: begin
						cmd.del_start = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_PLOAD: begin
				cmd.prn_load = 1'b1;
			end
			S_PAGES: begin
				if (stat.out_free) begin
					cmd.emit_nopage = stat.page_zero;
					cmd.emit_page = !stat.page_zero;
				end
			end
			S_DWALK: begin
				cmd.del_step = !stat.walk_done;
			end
			S_DDONE: begin
				cmd.del_finish = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					unique case (stat.op)
						CMD_ENQUEUE: begin
							if (stat.out_free) state_q <= S_IDLE;
						end
						CMD_PRINT: begin
							if (!stat.empty) state_q <= S_PLOAD;
							else if (stat.out_free) state_q <= S_IDLE;
						end
						CMD_DELETE: state_q <= S_DWALK;
						default: state_q <= S_IDLE;
					endcase
				end
				S_PLOAD: state_q <= S_PAGES;
				S_PAGES: begin
					if (stat.out_free && (stat.page_zero || stat.page_last)) begin
						state_q <= S_IDLE;
					end
				end
				S_DWALK: begin
					if (stat.walk_done) state_q <= S_DDONE;
				end
				S_DDONE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/pjq_datapath.sv =====
// Datapath of the print job queue: pointers, entry RAM, walk and output register.
// Depends on pjq_pkg, pjq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pjq_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pjq_pkg::pjq_cmd_t           cmd,
	output pjq_pkg::pjq_stat_t          stat,
	input  logic [pjq_pkg::OP_W-1:0]    command,
	input  logic [pjq_pkg::ID_W-1:0]    job_id,
	input  logic [pjq_pkg::PAGE_W-1:0]  page_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pjq_pkg::STATUS_W-1:0] status,
	output logic [pjq_pkg::ID_W-1:0]    out_job_id,
	output logic [pjq_pkg::PAGE_W-1:0]  page_number,
	output logic                        last
);
	import pjq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	pjq_op_t            op_q;
	logic [ID_W-1:0]    id_q;
	logic [PAGE_W-1:0]  pg_q;
	logic [PAGE_W-1:0]  page_no_q;
	logic [PTR_W-1:0]   head_q, tail_q, src_q, dst_q;
	logic [CNT_W-1:0]   cnt_q, rem_q, kept_q;
	logic               found_q, rd_pend_q;

	logic               out_valid_q, last_q;
	pjq_status_t        status_q;
	logic [ID_W-1:0]    out_id_q;
	logic [PAGE_W-1:0]  page_q;

	logic               ram_wr_en, ram_rd_en;
	logic [PTR_W-1:0]   ram_wr_addr, ram_rd_addr;
	logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
	logic [ID_W-1:0]    rd_id;
	logic [PAGE_W-1:0]  rd_pages;
	logic               issue, keep, out_free, any_emit;

	assign rd_id = ram_rd_data[ENTRY_W-1:PAGE_W];
	assign rd_pages = ram_rd_data[PAGE_W-1:0];
	assign issue = cmd.del_step && (rem_q != '0);
	assign keep = cmd.del_step && rd_pend_q && (rd_id != id_q);
	assign out_free = !out_valid_q || !out_stall;
	assign any_emit = cmd.emit_full | cmd.emit_empty | cmd.enq | cmd.emit_page |
		cmd.emit_nopage | cmd.del_finish;

	assign stat.op = op_q;
	assign stat.full = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);
	assign stat.out_free = out_free;
	assign stat.walk_done = (rem_q == '0) && !rd_pend_q;
	assign stat.page_zero = (pg_q == '0);
	assign stat.page_last = (page_no_q == pg_q);

	always_comb begin
		ram_wr_en = cmd.enq | keep;
		ram_wr_addr = cmd.enq ? tail_q : dst_q;
		ram_wr_data = cmd.enq ? {id_q, pg_q} : ram_rd_data;
		ram_rd_en = cmd.prn_read | issue;
		ram_rd_addr = cmd.prn_read ? head_q : src_q;
	end

	pjq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Item registers and delete walk.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= pjq_op_t'(command);
			id_q <= job_id;
			pg_q <= (page_count > MAX_PAGES) ? MAX_PAGES : page_count;
		end
		if (cmd.prn_load) begin
			id_q <= rd_id;
			pg_q <= (rd_pages > MAX_PAGES) ? MAX_PAGES : rd_pages;
			page_no_q <= PAGE_W'(1);
		end
		if (cmd.emit_page) begin
			page_no_q <= page_no_q + PAGE_W'(1);
		end
		if (cmd.del_start) begin
			src_q <= head_q;
			dst_q <= head_q;
			rem_q <= cnt_q;
			kept_q <= '0;
			found_q <= 1'b0;
		end
		if (issue) begin
			src_q <= ptr_next(src_q);
			rem_q <= rem_q - CNT_W'(1);
		end
		if (keep) begin
			dst_q <= ptr_next(dst_q);
			kept_q <= kept_q + CNT_W'(1);
		end
		if (cmd.del_step && rd_pend_q && (rd_id == id_q)) begin
			found_q <= 1'b1;
		end
	end

	// Queue pointers and read pipeline flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cmd.enq) begin
				tail_q <= ptr_next(tail_q);
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.prn_read) begin
				head_q <= ptr_next(head_q);
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.del_finish) begin
				tail_q <= dst_q;
				cnt_q <= kept_q;
			end
			if (cmd.del_start) begin
				rd_pend_q <= 1'b0;
			end else if (cmd.del_step) begin
				rd_pend_q <= issue;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (any_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (any_emit) begin
			out_id_q <= cmd.emit_empty ? '0 : id_q;
			page_q <= cmd.emit_page ? page_no_q : '0;
			last_q <= cmd.emit_page ? (page_no_q == pg_q) : 1'b1;
			priority if (cmd.emit_full) begin
				status_q <= ST_FULL;
			end else if (cmd.emit_empty) begin
				status_q <= ST_EMPTY;
			end else if (cmd.emit_nopage) begin
				status_q <= ST_NO_PAGES;
			end else if (cmd.emit_page) begin
				status_q <= ST_OK;
			end else if (cmd.del_finish) begin
				status_q <= found_q ? ST_OK : ST_NOT_FOUND;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_job_id = out_id_q;
	assign page_number = page_q;
	assign last = last_q;

	`PJQ_ASSERT(a_cnt_range, cnt_q <= CNT_FULL, "entry count above queue depth")
	`PJQ_ASSERT(a_emit_free, any_emit |-> out_free, "result loaded over a pending transfer")
	`PJQ_ASSERT(a_emit_one, $onehot0({cmd.emit_full, cmd.emit_empty, cmd.enq, cmd.emit_page, cmd.emit_nopage, cmd.del_finish}), "two results loaded at once")
	`PJQ_NEVER(a_enq_full, cmd.enq && stat.full, "enqueue into full queue")

endmodule

// ===== hdl/print_job_queue_core.sv =====
// Top level of the print job queue: controller plus datapath.
// Depends on pjq_pkg, pjq_ctrl, pjq_datapath and pjq_ram.
`timescale 1ns / 1ps
//
// Usage: an input transfer (in_valid high, in_stall low) carries command,
// job_id and page_count. Commands: enqueue, print head job, delete by number.
// Every command but the unused code gives results on the output channel,
// one per transfer (out_valid high, out_stall low); last marks the final one.
// Enqueue: one result.
// Print: the head job is read from the entry RAM and loaded, then one page
// per cycle while out_stall is low, up to 64 pages; empty queue or no pages
// gives a single status result.
// Delete: walks the stored jobs through the entry RAM, one per cycle, then
// gives its status result.
// One item is worked at a time; in_stall is high until the item's last
// result sits in the output register, which then holds while out_stall is
// high and the next item can already be taken.
// Reset empties the queue; stored entries are not cleared.
//
module print_job_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pjq_pkg::OP_W-1:0]     command,
	input  logic [pjq_pkg::ID_W-1:0]     job_id,
	input  logic [pjq_pkg::PAGE_W-1:0]   page_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pjq_pkg::STATUS_W-1:0] status,
	output logic [pjq_pkg::ID_W-1:0]     out_job_id,
	output logic [pjq_pkg::PAGE_W-1:0]   page_number,
	output logic                         last
);
	import pjq_pkg::*;

	pjq_cmd_t  cmd;
	pjq_stat_t stat;

	pjq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (in_stall)
	);

	pjq_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.command    (command),
		.job_id     (job_id),
		.page_count (page_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_job_id (out_job_id),
		.page_number(page_number),
		.last       (last)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for print_job_queue_core: directed table, then random traffic.
// Holds its own job queue predictor and compares every output transfer; needs pjq_pkg.
module testbench;
	import pjq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 140;
	localparam int PHASE_LEN = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [OP_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     job;
		logic [PAGE_W-1:0]   page;
		logic                last;
	} job_result_t;

	typedef struct packed {
		logic [OP_W-1:0]   cmd;
		logic [ID_W-1:0]   job;
		logic [PAGE_W-1:0] pages;
		logic [4:0]        reps;
		logic              typed;
		pjq_status_t       t_status;
		logic [ID_W-1:0]   t_job;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [OP_W-1:0] command;
	logic [ID_W-1:0] job_id;
	logic [PAGE_W-1:0] page_count;
	logic out_valid;
	logic out_stall;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] out_job_id;
	logic [PAGE_W-1:0] page_number;
	logic last;

	logic [ID_W-1:0] held_job [DEPTH];
	logic [PAGE_W-1:0] held_pages [DEPTH];
	int head_slot;
	int held_count;

	job_result_t expected_results [$];
	job_result_t predicted [$];
	int failures = 0;
	int cycles = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;

	stim_row_t directed_rows [24] = '{
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b1, ST_EMPTY,     16'h0000},
		'{CMD_DELETE,  16'h1234, 7'd0,   5'd1,  1'b1, ST_NOT_FOUND, 16'h1234},
		'{CMD_UNUSED,  16'hFFFF, 7'h7F,  5'd1,  1'b0, ST_OK,        16'h0000},
		'{CMD_ENQUEUE, 16'hFFFF, 7'h7F,  5'd1,  1'b1, ST_OK,        16'hFFFF},
		'{CMD_ENQUEUE, 16'h0000, 7'd0,   5'd1,  1'b1, ST_OK,        16'h0000},
		'{CMD_ENQUEUE, 16'hAAAA, 7'd64,  5'd1,  1'b1, ST_OK,        16'hAAAA},
		'{CMD_ENQUEUE, 16'h5555, 7'd65,  5'd1,  1'b1, ST_OK,        16'h5555},
		'{CMD_PRINT,   16'h3C3C, 7'd0,   5'd1,  1'b0, ST_OK,        16'h0000},
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b1, ST_NO_PAGES,  16'h0000},
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b0, ST_OK,        16'h0000},
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b0, ST_OK,        16'h0000},
		'{CMD_ENQUEUE, 16'h0F0F, 7'd1,   5'd16, 1'b1, ST_OK,        16'h0F0F},
		'{CMD_ENQUEUE, 16'hF0F0, 7'd2,   5'd1,  1'b1, ST_FULL,      16'hF0F0},
		'{CMD_DELETE,  16'h0F0F, 7'd0,   5'd1,  1'b1, ST_OK,        16'h0F0F},
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b1, ST_EMPTY,     16'h0000},
		'{CMD_ENQUEUE, 16'h0001, 7'd2,   5'd1,  1'b1, ST_OK,        16'h0001},
		'{CMD_ENQUEUE, 16'h0002, 7'd3,   5'd1,  1'b1, ST_OK,        16'h0002},
		'{CMD_ENQUEUE, 16'h0001, 7'd1,   5'd1,  1'b1, ST_OK,        16'h0001},
		'{CMD_ENQUEUE, 16'h0003, 7'd0,   5'd1,  1'b1, ST_OK,        16'h0003},
		'{CMD_DELETE,  16'h0001, 7'd0,   5'd1,  1'b1, ST_OK,        16'h0001},
		'{CMD_DELETE,  16'h0001, 7'd0,   5'd1,  1'b1, ST_NOT_FOUND, 16'h0001},
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b0, ST_OK,        16'h0000},
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b1, ST_NO_PAGES,  16'h0003},
		'{CMD_PRINT,   16'h0000, 7'd0,   5'd1,  1'b1, ST_EMPTY,     16'h0000}
	};

	print_job_queue_core #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.job_id(job_id),
		.page_count(page_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_job_id(out_job_id),
		.page_number(page_number),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic job_result_t make_result(input logic [STATUS_W-1:0] st,
			input logic [ID_W-1:0] job, input logic [PAGE_W-1:0] page, input logic fin);
		job_result_t res;
		res.status = st;
		res.job = job;
		res.page = page;
		res.last = fin;
		return res;
	endfunction

	task automatic predict_command(input logic [OP_W-1:0] cmd, input logic [ID_W-1:0] job,
			input logic [PAGE_W-1:0] pages);
		int slot;
		int kept;
		int src;
		logic found;
		logic [ID_W-1:0] head_job;
		logic [PAGE_W-1:0] head_pages;
		predicted.delete();
		case (cmd)
			CMD_ENQUEUE: begin
				if (held_count >= DEPTH) begin
					predicted.push_back(make_result(ST_FULL, job, '0, 1'b1));
				end else begin
					slot = (head_slot + held_count) % DEPTH;
					held_job[slot] = job;
					held_pages[slot] = (pages > MAX_PAGES) ? MAX_PAGES : pages;
					held_count++;
					predicted.push_back(make_result(ST_OK, job, '0, 1'b1));
				end
			end
			CMD_PRINT: begin
				if (held_count == 0) begin
					predicted.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
				end else begin
					head_job = held_job[head_slot];
					head_pages = held_pages[head_slot];
					head_slot = (head_slot + 1) % DEPTH;
					held_count--;
					if (head_pages == 0)
						predicted.push_back(make_result(ST_NO_PAGES, head_job, '0, 1'b1));
					for (int p = 1; p <= head_pages; p++)
						predicted.push_back(make_result(ST_OK, head_job, PAGE_W'(p),
							p == head_pages));
				end
			end
			CMD_DELETE: begin
				found = 1'b0;
				kept = 0;
				for (int i = 0; i < held_count; i++) begin
					src = (head_slot + i) % DEPTH;
					if (held_job[src] == job) begin
						found = 1'b1;
					end else begin
						slot = (head_slot + kept) % DEPTH;
						held_job[slot] = held_job[src];
						held_pages[slot] = held_pages[src];
						kept++;
					end
				end
				held_count = kept;
				predicted.push_back(make_result(found ? ST_OK : ST_NOT_FOUND, job, '0, 1'b1));
			end
			default: ;
		endcase
	endtask

	task automatic send_command(input stim_row_t row);
		int gap;
		gap = sender_idles ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		command = row.cmd;
		job_id = row.job;
		page_count = row.pages;
		do @(posedge clk); while (in_stall);
		predict_command(row.cmd, row.job, row.pages);
		if (row.typed)
			expected_results.push_back(make_result(row.t_status, row.t_job, '0, 1'b1));
		else
			foreach (predicted[i]) expected_results.push_back(predicted[i]);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	function automatic stim_row_t random_row(input bit filling);
		stim_row_t row;
		int pick;
		row = '0;
		row.reps = 5'd1;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			row.cmd = CMD_UNUSED;
		else if (pick < (filling ? 60 : 30))
			row.cmd = CMD_ENQUEUE;
		else if (pick < (filling ? 82 : 80))
			row.cmd = CMD_PRINT;
		else
			row.cmd = CMD_DELETE;
		if ($urandom_range(0, 3) == 0)
			row.job = ID_W'($urandom_range(0, 65535));
		else
			row.job = ID_W'($urandom_range(1, 6));
		pick = $urandom_range(0, 9);
		if (pick < 7)
			row.pages = PAGE_W'($urandom_range(0, 3));
		else if (pick < 9)
			row.pages = PAGE_W'($urandom_range(4, 16));
		else
			row.pages = PAGE_W'($urandom_range(0, 127));
		return row;
	endfunction

	// output side: random stall before each transfer while receiver_idles is set
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = receiver_idles ? $urandom_range(0, 4) : 0;
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		job_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with none expected: status %0d job %h page %0d last %0b",
					status, out_job_id, page_number, last);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failures++;
				end
				if (out_job_id !== want.job) begin
					$error("out_job_id: expected %h, got %h", want.job, out_job_id);
					failures++;
				end
				if (page_number !== want.page) begin
					$error("page_number: expected %0d, got %0d", want.page, page_number);
					failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		int issued;
		int phase;
		stim_row_t row;
		in_valid = 1'b0;
		command = CMD_ENQUEUE;
		job_id = '0;
		page_count = '0;
		head_slot = 0;
		held_count = 0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			for (int k = 0; k < directed_rows[r].reps; k++)
				send_command(directed_rows[r]);
		wait_for_results();

		// alternate filling and draining phases, idling switched per phase
		issued = 0;
		phase = -1;
		while (issued < RANDOM_ITEMS) begin
			if (issued / PHASE_LEN != phase) begin
				phase = issued / PHASE_LEN;
				sender_idles = $urandom_range(0, 3) != 0;
				receiver_idles = $urandom_range(0, 3) != 0;
			end
			row = random_row(phase % 2 == 0);
			send_command(row);
			if (row.cmd != CMD_UNUSED)
				issued++;
			if (issued == RANDOM_ITEMS / 2 && row.cmd != CMD_UNUSED)
				wait_for_results();
		end

		in_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
